### src/imu_spd_pkg.sv
// shared types and constants for the imu serial packet deframer
package imu_spd_pkg;

    // packet framing bytes
    localparam logic [7:0] HEADER_BYTE = 8'h55;
    localparam logic [7:0] TYPE_ACCEL  = 8'h51;
    localparam logic [7:0] TYPE_RATE   = 8'h52;
    localparam logic [7:0] TYPE_ANGLE  = 8'h53;

    // packet kind codes
    localparam logic [1:0] KIND_ACCEL = 2'd0;
    localparam logic [1:0] KIND_RATE  = 2'd1;
    localparam logic [1:0] KIND_ANGLE = 2'd2;

    // configuration register indexes
    localparam int         CFG_IDX_W     = 2;
    localparam logic [1:0] REG_ACCEL_GAIN = 2'd0;
    localparam logic [1:0] REG_RATE_GAIN  = 2'd1;
    localparam logic [1:0] REG_ANGLE_GAIN = 2'd2;

    // field widths
    localparam int GAIN_W  = 20;
    localparam int RAW_W   = 16;
    localparam int SCALE_W = 20;
    localparam int TOTAL_W = 16;
    localparam int PROD_W  = RAW_W + GAIN_W + 1;

    // reset gains, q.8 full scale
    localparam logic [GAIN_W-1:0] ACCEL_GAIN_RST = 20'd40141;
    localparam logic [GAIN_W-1:0] RATE_GAIN_RST  = 20'd512000;
    localparam logic [GAIN_W-1:0] ANGLE_GAIN_RST = 20'd46080;

    // saturation limits of the scaled value
    localparam logic [SCALE_W-1:0] SCALED_MAX = 20'h7FFFF;
    localparam logic [SCALE_W-1:0] SCALED_MIN = 20'h80000;

    // one parsed word on its way to the scaler
    typedef struct packed {
        logic                    ready;
        logic [1:0]              kind;
        logic [2:0][RAW_W-1:0]   raw;
        logic [GAIN_W-1:0]       gain;
        logic [TOTAL_W-1:0]      cs_total;
        logic [TOTAL_W-1:0]      hdr_total;
        logic                    synced;
    } imu_spd_item_t;

endpackage

### src/imu_spd_parse.sv
// byte window, checksum and header check, sync state, error counters and gain registers
module imu_spd_parse #(
    parameter int PACKET_BYTES = 11,
    parameter int COUNTER_BITS = 16
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_we,
    input  logic [imu_spd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [imu_spd_pkg::GAIN_W-1:0]        cfg_wdata,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [7:0]                            rx_byte,
    output logic                                  item_valid,
    input  logic                                  item_take,
    output imu_spd_pkg::imu_spd_item_t            item
);
    import imu_spd_pkg::*;

    localparam int SKIP_W = $clog2(PACKET_BYTES);
    localparam int EXT_W  = (COUNTER_BITS > TOTAL_W) ? COUNTER_BITS : TOTAL_W;

    logic [7:0]              win_reg [PACKET_BYTES];
    logic [7:0]              win_next [PACKET_BYTES];
    logic [SKIP_W-1:0]       skip_reg, skip_next;
    logic                    sync_reg, sync_next;
    logic [COUNTER_BITS-1:0] cs_reg, cs_next;
    logic [COUNTER_BITS-1:0] hdr_reg, hdr_next;
    logic [GAIN_W-1:0]       accel_gain_reg, rate_gain_reg, angle_gain_reg;
    logic                    valid_reg;
    imu_spd_item_t           item_reg, item_next;
    logic [7:0]              axis_byte [6];
    logic [7:0]              sum;
    logic                    fire;
    logic [EXT_W-1:0]        cs_ext, hdr_ext;

    assign s_tready   = !valid_reg || item_take;
    assign fire       = s_tvalid && s_tready;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    // shift the new byte into the window
    always_comb begin
        for (int i = 0; i < PACKET_BYTES - 1; i++) begin
            win_next[i] = win_reg[i + 1];
        end
        win_next[PACKET_BYTES-1] = rx_byte;
    end

    // axis bytes, zero where the window is too short
    for (genvar j = 0; j < 6; j++) begin : g_axis
        if (j + 2 < PACKET_BYTES) begin : g_in
            assign axis_byte[j] = win_next[j + 2];
        end else begin : g_out
            assign axis_byte[j] = 8'd0;
        end
    end

    // modulo-256 sum of the older bytes
    always_comb begin
        sum = 8'd0;
        for (int i = 0; i < PACKET_BYTES - 1; i++) begin
            sum = sum + win_next[i];
        end
    end

    // packet checks and state update
    always_comb begin
        skip_next = skip_reg;
        sync_next = sync_reg;
        cs_next   = cs_reg;
        hdr_next  = hdr_reg;
        item_next = '0;
        if (skip_reg != '0) begin
            skip_next = skip_reg - 1'b1;
        end else if (sum != rx_byte) begin
            if (sync_reg) begin
                sync_next = 1'b0;
                if (cs_reg != '1) cs_next = cs_reg + 1'b1;
            end
        end else if (win_next[0] != HEADER_BYTE) begin
            if (hdr_reg != '1) hdr_next = hdr_reg + 1'b1;
        end else begin
            unique case (win_next[1])
                TYPE_ACCEL: begin
                    item_next.ready = 1'b1;
                    item_next.kind  = KIND_ACCEL;
                    item_next.gain  = accel_gain_reg;
                end
                TYPE_RATE: begin
                    item_next.ready = 1'b1;
                    item_next.kind  = KIND_RATE;
                    item_next.gain  = rate_gain_reg;
                end
                TYPE_ANGLE: begin
                    item_next.ready = 1'b1;
                    item_next.kind  = KIND_ANGLE;
                    item_next.gain  = angle_gain_reg;
                end
                default: begin
                    if (hdr_reg != '1) hdr_next = hdr_reg + 1'b1;
                end
            endcase
            if (item_next.ready) begin
                sync_next = 1'b1;
                skip_next = SKIP_W'(PACKET_BYTES - 1);
                for (int k = 0; k < 3; k++) begin
                    item_next.raw[k] = {axis_byte[2*k+1], axis_byte[2*k]};
                end
            end
        end
        cs_ext              = EXT_W'(cs_next);
        hdr_ext             = EXT_W'(hdr_next);
        item_next.cs_total  = cs_ext[TOTAL_W-1:0];
        item_next.hdr_total = hdr_ext[TOTAL_W-1:0];
        item_next.synced    = sync_next;
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < PACKET_BYTES; i++) win_reg[i] <= 8'd0;
            skip_reg  <= '0;
            sync_reg  <= 1'b0;
            cs_reg    <= '0;
            hdr_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            if (fire) begin
                win_reg  <= win_next;
                skip_reg <= skip_next;
                sync_reg <= sync_next;
                cs_reg   <= cs_next;
                hdr_reg  <= hdr_next;
            end
            if (s_tready) valid_reg <= s_tvalid;
        end
    end

    // word register toward the scaler
    always_ff @(posedge aclk) begin
        if (fire) item_reg <= item_next;
    end

    // gain registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            accel_gain_reg <= ACCEL_GAIN_RST;
            rate_gain_reg  <= RATE_GAIN_RST;
            angle_gain_reg <= ANGLE_GAIN_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_ACCEL_GAIN: accel_gain_reg <= cfg_wdata;
                REG_RATE_GAIN:  rate_gain_reg  <= cfg_wdata;
                REG_ANGLE_GAIN: angle_gain_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

endmodule

### src/imu_spd_scale.sv
// gain multiply, then rounding and saturation into the result register
module imu_spd_scale (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  item_valid,
    output logic                                  item_take,
    input  imu_spd_pkg::imu_spd_item_t            item,
    output logic                                  out_valid,
    input  logic                                  out_take,
    output imu_spd_pkg::imu_spd_item_t            out_item,
    output logic [2:0][imu_spd_pkg::SCALE_W-1:0]  out_scaled
);
    import imu_spd_pkg::*;

    logic                            prod_valid_reg;
    imu_spd_item_t                   prod_item_reg;
    logic signed [PROD_W-1:0]        prod_reg [3];
    logic signed [PROD_W-1:0]        prod_next [3];
    logic                            res_valid_reg;
    imu_spd_item_t                   res_item_reg;
    logic [2:0][SCALE_W-1:0]         res_scaled_reg, res_scaled_next;
    logic                            prod_take;
    logic [PROD_W-1:0]               mag [3];
    logic [PROD_W-1:0]               rnd [3];
    logic [PROD_W-16:0]              quo [3];
    logic [PROD_W-16:0]              quo_neg [3];

    // stall chain: a stage moves when the one after it has room
    assign prod_take  = !res_valid_reg || out_take;
    assign item_take  = !prod_valid_reg || prod_take;
    assign out_valid  = res_valid_reg;
    assign out_item   = res_item_reg;
    assign out_scaled = res_scaled_reg;

    // raw times gain, gain taken as unsigned
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            prod_next[k] = PROD_W'($signed(item.raw[k])) *
                           PROD_W'($signed({1'b0, item.gain}));
        end
    end

    // divide by 32768 rounding halves away from zero, then saturate
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            mag[k]     = prod_reg[k][PROD_W-1] ? PROD_W'(-prod_reg[k]) : PROD_W'(prod_reg[k]);
            rnd[k]     = mag[k] + PROD_W'(16384);
            quo[k]     = rnd[k][PROD_W-1:15];
            quo_neg[k] = -quo[k];
            if (!prod_reg[k][PROD_W-1]) begin
                res_scaled_next[k] = (quo[k] > (PROD_W-15)'(SCALED_MAX)) ?
                                     SCALED_MAX : quo[k][SCALE_W-1:0];
            end else begin
                res_scaled_next[k] = (quo[k] > (PROD_W-15)'(SCALED_MIN)) ?
                                     SCALED_MIN : quo_neg[k][SCALE_W-1:0];
            end
        end
    end

    // valid flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end else begin
            if (item_take) prod_valid_reg <= item_valid;
            if (prod_take) res_valid_reg  <= prod_valid_reg;
        end
    end

    // product and result payload
    always_ff @(posedge aclk) begin
        if (item_take && item_valid) begin
            prod_item_reg <= item;
            prod_reg      <= prod_next;
        end
        if (prod_take && prod_valid_reg) begin
            res_item_reg   <= prod_item_reg;
            res_scaled_reg <= res_scaled_next;
        end
    end

endmodule

### src/imu_serial_packet_deframer.sv
// top level of the imu serial packet deframer
//
//  channel   direction  content
//  s_axis    in         tdata[7:0] rx_byte
//  m_axis    out        tuser: ready, kind; tdata: raw, scaled, totals, synced
//  cfg       in         cfg_we, cfg_index, cfg_wdata (three gain registers)
//
// one byte is taken per cycle while s_tready is high; its result reaches m_tvalid
// through the parse register, product register and result register.
// reset is synchronous and active low; the window, counters and sync clear.
// a stalled output holds the pipeline; s_tready drops only when all three
// stages are full and m_tready is low.
module imu_serial_packet_deframer #(
    parameter int PACKET_BYTES = 11,
    parameter int COUNTER_BITS = 16
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  logic [imu_spd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [imu_spd_pkg::GAIN_W-1:0]     cfg_wdata,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [7:0]                         s_tdata,   // rx_byte
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // packet_ready, packet_kind[1:0]
    output logic [2:0]                         m_tuser,
    // raw_x, raw_y, raw_z, scaled_x, scaled_y, scaled_z,
    // checksum_error_total, header_error_total, synced, 3 zero bits
    output logic [143:0]                       m_tdata
);
    import imu_spd_pkg::*;

    logic                     item_valid;
    logic                     item_take;
    imu_spd_item_t            item;
    imu_spd_item_t            out_item;
    logic [2:0][SCALE_W-1:0]  out_scaled;

    // framing, checks and state
    imu_spd_parse #(
        .PACKET_BYTES (PACKET_BYTES),
        .COUNTER_BITS (COUNTER_BITS)
    ) u_parse (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .rx_byte    (s_tdata),
        .item_valid (item_valid),
        .item_take  (item_take),
        .item       (item)
    );

    // gain scaling and result register
    imu_spd_scale u_scale (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (item_valid),
        .item_take  (item_take),
        .item       (item),
        .out_valid  (m_tvalid),
        .out_take   (m_tready),
        .out_item   (out_item),
        .out_scaled (out_scaled)
    );

    // pack the result word
    assign m_tuser = {out_item.kind, out_item.ready};
    assign m_tdata = {3'b000,
                      out_item.synced,
                      out_item.hdr_total,
                      out_item.cs_total,
                      out_scaled[2],
                      out_scaled[1],
                      out_scaled[0],
                      out_item.raw[2],
                      out_item.raw[1],
                      out_item.raw[0]};

endmodule
